// File: design/smta_pkg.sv
// ----------------------------------------------------------------------------
// smta_pkg
// shared types and codes for the sparse matrix coordinate-list adder
// ----------------------------------------------------------------------------
package smta_pkg;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_SUM   = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    localparam logic CFG_ROW = 1'b0;
    localparam logic CFG_COL = 1'b1;

    // source of the result fields
    localparam logic [1:0] RES_ECHO  = 2'd0;
    localparam logic [1:0] RES_HIT   = 2'd1;
    localparam logic [1:0] RES_MERGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WSCAN,
        S_WSHIFT,
        S_RSCAN,
        S_SUMLD,
        S_SUM,
        S_EMIT,
        S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic rd_issue;   // register memory read at cursor(s)
        logic wr_step;    // shift one entry up (write at cursor, from cursor-1)
        logic wr_put;     // write new entry at cursor
        logic wr_val;     // overwrite value at cursor
        logic cur_dec;    // cursor down
        logic cur_inc;    // cursor up
        logic set_cur_n;  // cursor <- count
        logic set_cur_0;  // cursor <- 0
        logic cnt_inc;    // count of selected table + 1
        logic res_load;   // capture a result into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic     range_bad;
        logic     full;
        logic     at_end;     // cursor reached count
        logic     at_zero;
        logic     match;      // registered entry equals request key
        logic     greater;    // registered entry beyond request key
        logic     sum_done;   // both merge cursors at end
        logic     both_empty;
        logic     out_busy;
        logic     kind_none;
        logic     kind_write;
        logic     kind_read;
    } t_stat;

endpackage

// File: design/smta_ctrl.sv
// ----------------------------------------------------------------------------
// smta_ctrl
// sequencer for write scan/shift, read scan and sum merge
// ----------------------------------------------------------------------------
module smta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  smta_pkg::t_stat   i_stat,
    output smta_pkg::t_cmd    o_cmd,
    output smta_pkg::t_status o_res_status,
    output logic [1:0]        o_res_sel,
    output logic              o_res_last
);
    smta_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smta_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_res_status = smta_pkg::ST_OK;
        o_res_sel    = smta_pkg::RES_ECHO;
        o_res_last   = 1'b1;
        case (r_state)
            smta_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = smta_pkg::S_SUMLD;
                end
            end
            smta_pkg::S_SUMLD: begin
                // decode latched request
                o_cmd.set_cur_0 = 1'b1;
                o_cmd.rd_issue  = 1'b1;
                if (i_stat.kind_none) begin
                    n_state = smta_pkg::S_IDLE;
                end else if (i_stat.kind_write) begin
                    n_state = smta_pkg::S_WSCAN;
                end else if (i_stat.kind_read) begin
                    n_state = smta_pkg::S_RSCAN;
                end else begin
                    n_state = smta_pkg::S_SUM;
                end
            end
            smta_pkg::S_WSCAN: begin
                // memory data at cursor is registered; cursor holds its index
                if (i_stat.range_bad) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.res_load = 1'b1;
                        o_res_status   = smta_pkg::ST_RANGE;
                        n_state        = smta_pkg::S_IDLE;
                    end
                end else if (!i_stat.at_end && i_stat.match) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.wr_val   = 1'b1;
                        o_cmd.res_load = 1'b1;
                        n_state        = smta_pkg::S_IDLE;
                    end
                end else if (i_stat.at_end || i_stat.greater) begin
                    if (i_stat.full) begin
                        if (!i_stat.out_busy) begin
                            o_cmd.res_load = 1'b1;
                            o_res_status   = smta_pkg::ST_FULL;
                            n_state        = smta_pkg::S_IDLE;
                        end
                    end else begin
                        o_cmd.set_cur_n = 1'b1;
                        n_state         = smta_pkg::S_WSHIFT;
                    end
                end else begin
                    o_cmd.cur_inc  = 1'b1;
                    o_cmd.rd_issue = 1'b1;
                end
            end
            smta_pkg::S_WSHIFT: begin
                // cursor walks down from count to insert position
                if (i_stat.at_zero || i_stat.greater == 1'b0) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.wr_put   = 1'b1;
                        o_cmd.cnt_inc  = 1'b1;
                        o_cmd.res_load = 1'b1;
                        n_state        = smta_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.wr_step = 1'b1;
                    o_cmd.cur_dec = 1'b1;
                end
            end
            smta_pkg::S_RSCAN: begin
                if (i_stat.at_end || i_stat.match) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.res_load = 1'b1;
                        o_res_sel      = (!i_stat.at_end && i_stat.match) ?
                                         smta_pkg::RES_HIT : smta_pkg::RES_ECHO;
                        n_state        = smta_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.cur_inc  = 1'b1;
                    o_cmd.rd_issue = 1'b1;
                end
            end
            smta_pkg::S_SUM: begin
                if (i_stat.both_empty) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.res_load = 1'b1;
                        o_res_status   = smta_pkg::ST_EMPTY;
                        n_state        = smta_pkg::S_IDLE;
                    end
                end else begin
                    n_state = smta_pkg::S_EMIT;
                end
            end
            smta_pkg::S_EMIT: begin
                // one merged entry per step; datapath advances cursors
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.cur_inc  = 1'b1;
                    o_res_sel      = smta_pkg::RES_MERGE;
                    o_res_last     = 1'b0;
                    n_state        = smta_pkg::S_OUT;
                end
            end
            smta_pkg::S_OUT: begin
                // wait for the advanced cursors to read back
                if (i_stat.sum_done) begin
                    n_state = smta_pkg::S_IDLE;
                end else begin
                    n_state = smta_pkg::S_EMIT;
                end
            end
            default: begin
                n_state = smta_pkg::S_IDLE;
            end
        endcase
    end
endmodule

// File: design/smta_dp.sv
// ----------------------------------------------------------------------------
// smta_dp
// entry memories, cursors, compare and output register
// ----------------------------------------------------------------------------
module smta_dp #(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_index,
    input  logic [8:0]              i_cfg_data,
    input  logic [1:0]              i_kind,
    input  logic                    i_matrix_sel,
    input  logic [INDEX_BITS-1:0]   i_row_index,
    input  logic [INDEX_BITS-1:0]   i_col_index,
    input  logic signed [31:0]      i_write_value,
    input  smta_pkg::t_cmd          i_cmd,
    input  smta_pkg::t_status       i_res_status,
    input  logic [1:0]              i_res_sel,
    input  logic                    i_res_last,
    output smta_pkg::t_stat         o_stat,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [1:0]              o_status,
    output logic [INDEX_BITS-1:0]   o_out_row,
    output logic [INDEX_BITS-1:0]   o_out_col,
    output logic signed [32:0]      o_out_value,
    output logic                    o_last
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 2 * INDEX_BITS + 32;
    localparam int KW = 2 * INDEX_BITS;

    // entry word: {row, col, value}; one memory per table
    logic [EW-1:0] r_mem_a [CAPACITY];
    logic [EW-1:0] r_mem_b [CAPACITY];
    logic [EW-1:0] r_rd_a, r_rd_b;

    logic [8:0]  r_row_cnt, r_col_cnt;
    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic [CW-1:0] r_cur_a, r_cur_b;   // r_cur_a is also the write/read cursor
    logic [1:0]  r_kind;
    logic        r_sel;
    logic [INDEX_BITS-1:0] r_row, r_col;
    logic [31:0] r_val;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic [INDEX_BITS-1:0] r_orow, r_ocol;
    logic [32:0] r_oval;
    logic        r_olast;

    logic [CW-1:0] w_cnt_sel, w_cur;
    logic [EW-1:0] w_rd_sel;
    logic [KW-1:0] w_key, w_key_sel, w_key_a, w_key_b;
    logic          w_a_ok, w_b_ok, w_take_a, w_take_b;
    logic [CW-1:0] w_na, w_nb;
    logic [CW-1:0] w_cur_m1;

    assign w_cnt_sel = r_sel ? r_cnt_b : r_cnt_a;
    assign w_cur     = r_cur_a;
    assign w_cur_m1  = w_cur - CW'(1);
    assign w_rd_sel  = r_sel ? r_rd_b : r_rd_a;
    assign w_key     = {r_row, r_col};
    assign w_key_sel = w_rd_sel[EW-1 -: KW];
    assign w_key_a   = r_rd_a[EW-1 -: KW];
    assign w_key_b   = r_rd_b[EW-1 -: KW];
    assign w_a_ok    = r_cur_a < r_cnt_a;
    assign w_b_ok    = r_cur_b < r_cnt_b;
    assign w_take_a  = w_a_ok && (!w_b_ok || w_key_a <= w_key_b);
    assign w_take_b  = w_b_ok && (!w_a_ok || w_key_b <= w_key_a);
    assign w_na      = w_take_a ? r_cur_a + CW'(1) : r_cur_a;
    assign w_nb      = w_take_b ? r_cur_b + CW'(1) : r_cur_b;

    always_comb begin
        o_stat            = '0;
        o_stat.range_bad  = ({1'b0, r_row} >= r_row_cnt) || ({1'b0, r_col} >= r_col_cnt);
        o_stat.full       = w_cnt_sel >= CW'(CAPACITY);
        o_stat.at_end     = w_cur >= w_cnt_sel;
        o_stat.at_zero    = w_cur == '0;
        o_stat.match      = w_key_sel == w_key;
        o_stat.greater    = w_key_sel > w_key;
        o_stat.sum_done   = !w_a_ok && !w_b_ok;
        o_stat.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
        o_stat.out_busy   = r_out_valid && !i_out_ready;
        o_stat.kind_none  = r_kind == smta_pkg::K_NONE;
        o_stat.kind_write = r_kind == smta_pkg::K_WRITE;
        o_stat.kind_read  = r_kind == smta_pkg::K_READ;
    end

    // memory read address: the updated cursor, or the entry below it while shifting
    logic [AW-1:0] w_ra_a, w_ra_b;
    logic          w_shift_rd;
    assign w_shift_rd = i_cmd.set_cur_n || i_cmd.wr_step;
    always_comb begin
        w_ra_a = AW'(r_cur_a);
        w_ra_b = AW'(r_sel ? r_cur_a : r_cur_b);
        if (i_cmd.set_cur_n) begin
            w_ra_a = AW'(w_cnt_sel - CW'(1));
            w_ra_b = AW'(w_cnt_sel - CW'(1));
        end else if (i_cmd.wr_step) begin
            w_ra_a = AW'(w_cur - CW'(2));
            w_ra_b = AW'(w_cur - CW'(2));
        end else if (i_cmd.cur_inc && r_kind == smta_pkg::K_SUM) begin
            w_ra_a = AW'(w_na);
            w_ra_b = AW'(w_nb);
        end else if (i_cmd.cur_inc) begin
            w_ra_a = AW'(r_cur_a + CW'(1));
            w_ra_b = AW'(r_cur_a + CW'(1));
        end else if (i_cmd.set_cur_0) begin
            w_ra_a = '0;
            w_ra_b = '0;
        end
    end

    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [EW-1:0] w_wd;
    always_comb begin
        w_we = i_cmd.wr_step || i_cmd.wr_put || i_cmd.wr_val;
        w_wa = AW'(w_cur);
        w_wd = w_rd_sel;
        if (i_cmd.wr_put || i_cmd.wr_val) begin
            w_wd = {r_row, r_col, r_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we && !r_sel) begin
            r_mem_a[w_wa] <= w_wd;
        end
        if (w_we && r_sel) begin
            r_mem_b[w_wa] <= w_wd;
        end
        if (i_cmd.rd_issue || i_cmd.cur_inc || w_shift_rd || i_cmd.set_cur_0) begin
            r_rd_a <= r_mem_a[w_ra_a];
            r_rd_b <= r_mem_b[w_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_sel  <= (i_kind == smta_pkg::K_SUM) ? 1'b0 : i_matrix_sel;
            r_row  <= i_row_index;
            r_col  <= i_col_index;
            r_val  <= i_write_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= 9'd256;
            r_col_cnt   <= 9'd256;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_cur_a     <= '0;
            r_cur_b     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_index == smta_pkg::CFG_ROW) begin
                r_row_cnt <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_index == smta_pkg::CFG_COL) begin
                r_col_cnt <= i_cfg_data;
            end
            if (i_cmd.cnt_inc && !r_sel) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (i_cmd.cnt_inc && r_sel) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
            if (i_cmd.set_cur_0) begin
                r_cur_a <= '0;
                r_cur_b <= '0;
            end else if (i_cmd.set_cur_n) begin
                r_cur_a <= w_cnt_sel;
            end else if (i_cmd.cur_dec) begin
                r_cur_a <= w_cur_m1;
            end else if (i_cmd.cur_inc && r_kind == smta_pkg::K_SUM) begin
                r_cur_a <= w_na;
                r_cur_b <= w_nb;
            end else if (i_cmd.cur_inc) begin
                r_cur_a <= r_cur_a + CW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_res_status;
            case (i_res_sel)
                smta_pkg::RES_HIT: begin
                    r_orow  <= r_row;
                    r_ocol  <= r_col;
                    r_oval  <= {w_rd_sel[31], w_rd_sel[31:0]};
                    r_olast <= i_res_last;
                end
                smta_pkg::RES_MERGE: begin
                    r_orow <= w_take_a ? w_key_a[KW-1 -: INDEX_BITS] : w_key_b[KW-1 -: INDEX_BITS];
                    r_ocol <= w_take_a ? w_key_a[INDEX_BITS-1:0] : w_key_b[INDEX_BITS-1:0];
                    r_oval <= (w_take_a ? {r_rd_a[31], r_rd_a[31:0]} : 33'd0)
                            + (w_take_b ? {r_rd_b[31], r_rd_b[31:0]} : 33'd0);
                    r_olast <= (w_na >= r_cnt_a) && (w_nb >= r_cnt_b);
                end
                default: begin
                    r_orow  <= (i_res_status == smta_pkg::ST_EMPTY) ? '0 : r_row;
                    r_ocol  <= (i_res_status == smta_pkg::ST_EMPTY) ? '0 : r_col;
                    r_oval  <= '0;
                    r_olast <= i_res_last;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_row   = r_orow;
    assign o_out_col   = r_ocol;
    assign o_out_value = r_oval;
    assign o_last      = r_olast;
endmodule

// File: design/sparse_matrix_table_add_core.sv
// ----------------------------------------------------------------------------
// sparse_matrix_table_add_core
// two row-major coordinate lists with write, read and merged sum
// ----------------------------------------------------------------------------
// channel   direction  signals
// cfg       in         i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data
// in        in         i_in_valid/o_in_ready, i_kind .. i_write_value
// out       out        o_out_valid/i_out_ready, o_status .. o_last
//
// one request at a time; a write scans to the insert point, then shifts the
// rest up one entry at a time; a read scans to the key or the end of the table;
// a sum emits one merged entry per step while the output is not held
// reset clears counts, cursors and the output valid, and sets the range registers to 256
// the sequencer holds while the result register is still occupied
// ----------------------------------------------------------------------------
module sparse_matrix_table_add_core #(
    parameter int CAPACITY   = 16,
    parameter int INDEX_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [8:0]            i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_kind,
    input  logic                  i_matrix_sel,
    input  logic [INDEX_BITS-1:0] i_row_index,
    input  logic [INDEX_BITS-1:0] i_col_index,
    input  logic signed [31:0]    i_write_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [INDEX_BITS-1:0] o_out_row,
    output logic [INDEX_BITS-1:0] o_out_col,
    output logic signed [32:0]    o_out_value,
    output logic                  o_last
);
    smta_pkg::t_cmd    w_cmd;
    smta_pkg::t_stat   w_stat;
    smta_pkg::t_status w_res_status;
    logic [1:0]        w_res_sel;
    logic              w_res_last;

    assign o_cfg_ready = 1'b1;

    smta_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_res_status (w_res_status),
        .o_res_sel    (w_res_sel),
        .o_res_last   (w_res_last)
    );

    smta_dp #(
        .CAPACITY   (CAPACITY),
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_kind        (i_kind),
        .i_matrix_sel  (i_matrix_sel),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_write_value (i_write_value),
        .i_cmd         (w_cmd),
        .i_res_status  (w_res_status),
        .i_res_sel     (w_res_sel),
        .i_res_last    (w_res_last),
        .o_stat        (w_stat),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col),
        .o_out_value   (o_out_value),
        .o_last        (o_last)
    );
endmodule
